/* design/aps_pkg.sv */
// ----------------------------------------------------------------------------
// Packed sexagesimal angle package
// Types, constants and the residue table shared by the angle packer blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

  localparam int ANGLE_W     = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;
  localparam int NSTAGE      = 9;

  localparam int FULL_TURN = 360;
  localparam int SIXTY     = 60;
  localparam int THOUSAND  = 1000;

  localparam int FOLD_W        = 20;
  localparam int QUOT360_W     = 12;
  localparam int MOD360_SHIFT  = 20;
  localparam int MOD360_RECIP  = 2912;
  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP_1000    = 65;
  localparam int RECIP_60      = 1092;

  typedef enum logic {
    FUNC_PACK  = 1'b0,
    FUNC_FIXED = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] whole_degrees;
    logic        [7:0]  arc_minutes;
    logic        [7:0]  arc_seconds;
    logic        [15:0] thousandths;
    logic signed [63:0] angle_fixed;
  } aps_in_t;

  typedef struct packed {
    logic [31:0] packed_angle;
    logic        negative;
    logic [8:0]  degree_part;
    logic [5:0]  minute_part;
    logic [5:0]  second_part;
    logic [9:0]  milli_part;
  } aps_out_t;

  typedef struct packed {
    func_t       func;
    logic        neg;
    logic [63:0] mag;
    logic [7:0]  mins;
    logic [7:0]  secs;
    logic [15:0] millis;
  } aps_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } aps_qstat_t;

  // 256^idx modulo 360 for idx 0 to 5; zero for idx 6 and 7
  function automatic logic [8:0] pow256_mod360(input logic [2:0] idx);
    logic [8:0] res;
    unique case (idx)
      3'd0:    res = 9'd1;
      3'd1:    res = 9'd256;
      3'd2:    res = 9'd16;
      3'd3:    res = 9'd136;
      3'd4:    res = 9'd256;
      3'd5:    res = 9'd16;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/aps_front.sv */
// ----------------------------------------------------------------------------
// Angle packer front end
// Accepts input transactions, picks the mode's signed source and takes its
// magnitude and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_front (
  input  wire  aps_pkg::aps_in_t    in_data,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  aps_pkg::aps_qstat_t q_stat,
  output logic                      q_push,
  output aps_pkg::aps_entry_t       q_entry
);

  logic [63:0] src;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    if (in_data.func == aps_pkg::FUNC_FIXED) begin
      src = in_data.angle_fixed;
    end else begin
      src = {{32{in_data.whole_degrees[31]}}, in_data.whole_degrees};
    end
    q_entry.func   = in_data.func;
    q_entry.neg    = src[63];
    q_entry.mag    = src[63] ? (64'd0 - src) : src;
    q_entry.mins   = in_data.arc_minutes;
    q_entry.secs   = in_data.arc_seconds;
    q_entry.millis = in_data.thousandths;
  end

endmodule

`default_nettype wire

/* design/aps_queue.sv */
// ----------------------------------------------------------------------------
// Angle packer decoupling queue
// Short first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       q_push,
  input  wire  aps_pkg::aps_entry_t q_entry,
  input  wire                       q_pop,
  output aps_pkg::aps_entry_t       q_data,
  output aps_pkg::aps_qstat_t       q_stat
);

  aps_pkg::aps_entry_t             mem_r [aps_pkg::QUEUE_DEPTH];
  logic [aps_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [aps_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [aps_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == aps_pkg::QCNT_W'(aps_pkg::QUEUE_DEPTH));
  assign do_push      = q_push && !q_stat.full;
  assign do_pop       = q_pop && q_stat.valid;
  assign q_data       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + aps_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + aps_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + aps_pkg::QCNT_W'(do_push) - aps_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_entry;
    end
  end

endmodule

`default_nettype wire

/* design/aps_back.sv */
// ----------------------------------------------------------------------------
// Angle packer datapath
// Nine-stage pipeline: fraction split by 60, 60 and 1000, degree residue
// modulo 360, then carries from thousandths up to degrees and word packing.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_back #(
  parameter int FRAC_BITS = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire  aps_pkg::aps_entry_t q_data,
  input  wire  aps_pkg::aps_qstat_t q_stat,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire                       out_stall,
  output aps_pkg::aps_out_t         out_data
);

  localparam int WHOLE_W = aps_pkg::ANGLE_W - FRAC_BITS;
  localparam int NCHUNK  = (WHOLE_W + 7) / 8;
  localparam int PAD_W   = NCHUNK * 8;
  localparam int FW      = aps_pkg::FOLD_W;
  localparam int QW      = aps_pkg::QUOT360_W;
  localparam logic [FRAC_BITS+9:0] HALF = (FRAC_BITS + 10)'(1) << (FRAC_BITS - 1);

  logic [aps_pkg::NSTAGE-1:0] vld_r;
  logic                       adv;

  assign adv       = !(vld_r[aps_pkg::NSTAGE-1] && out_stall);
  assign q_pop     = adv && q_stat.valid;
  assign out_valid = vld_r[aps_pkg::NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[aps_pkg::NSTAGE-2:0], q_stat.valid};
    end
  end

  // stage 1: whole-degree residue fold, first fraction step
  logic [WHOLE_W-1:0]     whole;
  logic [PAD_W-1:0]       whole_pad;
  logic [FRAC_BITS+5:0]   t1;
  logic [FW-1:0]          s1_fold_nxt, s1_fold_r;
  aps_pkg::func_t         s1_func_r;
  logic                   s1_neg_r;
  logic [5:0]             s1_min1_r;
  logic [FRAC_BITS-1:0]   s1_f1_r;
  logic [7:0]             s1_mins_r, s1_secs_r;
  logic [15:0]            s1_millis_r;

  always_comb begin
    if (q_data.func == aps_pkg::FUNC_FIXED) begin
      whole = q_data.mag[aps_pkg::ANGLE_W-1:FRAC_BITS];
    end else begin
      whole = WHOLE_W'(q_data.mag[31:0]);
    end
    whole_pad   = PAD_W'(whole);
    s1_fold_nxt = '0;
    for (int k = 0; k < NCHUNK; k++) begin
      s1_fold_nxt = s1_fold_nxt + FW'(whole_pad[8*k +: 8])
                    * FW'(aps_pkg::pow256_mod360(3'(k)));
    end
    t1 = (FRAC_BITS + 6)'(q_data.mag[FRAC_BITS-1:0]) * (FRAC_BITS + 6)'(aps_pkg::SIXTY);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r   <= q_data.func;
      s1_neg_r    <= q_data.neg;
      s1_fold_r   <= s1_fold_nxt;
      s1_min1_r   <= t1[FRAC_BITS+5:FRAC_BITS];
      s1_f1_r     <= t1[FRAC_BITS-1:0];
      s1_mins_r   <= q_data.mins;
      s1_secs_r   <= q_data.secs;
      s1_millis_r <= q_data.millis;
    end
  end

  // stage 2: second fraction step, quotient estimate for modulo 360
  logic [FRAC_BITS+5:0]   t2;
  logic [FW+QW-1:0]       p360;
  logic [QW-1:0]          s2_q_nxt, s2_q_r;
  aps_pkg::func_t         s2_func_r;
  logic                   s2_neg_r;
  logic [FW-1:0]          s2_fold_r;
  logic [5:0]             s2_min1_r, s2_sec1_r;
  logic [FRAC_BITS-1:0]   s2_f2_r;
  logic [7:0]             s2_mins_r, s2_secs_r;
  logic [15:0]            s2_millis_r;

  always_comb begin
    t2       = (FRAC_BITS + 6)'(s1_f1_r) * (FRAC_BITS + 6)'(aps_pkg::SIXTY);
    p360     = (FW + QW)'(s1_fold_r) * (FW + QW)'(aps_pkg::MOD360_RECIP);
    s2_q_nxt = QW'(p360 >> aps_pkg::MOD360_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_func_r   <= s1_func_r;
      s2_neg_r    <= s1_neg_r;
      s2_fold_r   <= s1_fold_r;
      s2_q_r      <= s2_q_nxt;
      s2_min1_r   <= s1_min1_r;
      s2_sec1_r   <= t2[FRAC_BITS+5:FRAC_BITS];
      s2_f2_r     <= t2[FRAC_BITS-1:0];
      s2_mins_r   <= s1_mins_r;
      s2_secs_r   <= s1_secs_r;
      s2_millis_r <= s1_millis_r;
    end
  end

  // stage 3: rounded thousandths, residue correction, mode merge
  logic [FRAC_BITS+9:0]   t3;
  logic [FW-1:0]          rem360;
  logic [8:0]             s3_deg_nxt, s3_deg_r;
  logic [7:0]             s3_mins_nxt, s3_mins_r, s3_secs_nxt, s3_secs_r;
  logic [15:0]            s3_millis_nxt, s3_millis_r;
  logic                   s3_neg_r;

  always_comb begin
    t3     = (FRAC_BITS + 10)'(s2_f2_r) * (FRAC_BITS + 10)'(aps_pkg::THOUSAND) + HALF;
    rem360 = s2_fold_r - FW'(s2_q_r) * FW'(aps_pkg::FULL_TURN);
    if (rem360 >= FW'(aps_pkg::FULL_TURN)) begin
      s3_deg_nxt = 9'(rem360 - FW'(aps_pkg::FULL_TURN));
    end else begin
      s3_deg_nxt = 9'(rem360);
    end
    if (s2_func_r == aps_pkg::FUNC_FIXED) begin
      s3_mins_nxt   = 8'(s2_min1_r);
      s3_secs_nxt   = 8'(s2_sec1_r);
      s3_millis_nxt = 16'(t3[FRAC_BITS+9:FRAC_BITS]);
    end else begin
      s3_mins_nxt   = s2_mins_r;
      s3_secs_nxt   = s2_secs_r;
      s3_millis_nxt = s2_millis_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_neg_r    <= s2_neg_r;
      s3_deg_r    <= s3_deg_nxt;
      s3_mins_r   <= s3_mins_nxt;
      s3_secs_r   <= s3_secs_nxt;
      s3_millis_r <= s3_millis_nxt;
    end
  end

  // stage 4: quotient estimate of thousandths by 1000
  logic [22:0] p1000;
  logic [6:0]  s4_mq_nxt, s4_mq_r;
  logic        s4_neg_r;
  logic [8:0]  s4_deg_r;
  logic [7:0]  s4_mins_r, s4_secs_r;
  logic [15:0] s4_millis_r;

  always_comb begin
    p1000     = 23'(s3_millis_r) * 23'(aps_pkg::RECIP_1000);
    s4_mq_nxt = 7'(p1000 >> aps_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_neg_r    <= s3_neg_r;
      s4_deg_r    <= s3_deg_r;
      s4_mins_r   <= s3_mins_r;
      s4_secs_r   <= s3_secs_r;
      s4_millis_r <= s3_millis_r;
      s4_mq_r     <= s4_mq_nxt;
    end
  end

  // stage 5: correct thousandths, carry into seconds
  logic [15:0] mrem;
  logic [6:0]  mcarry;
  logic [9:0]  s5_milli_nxt, s5_milli_r;
  logic [8:0]  s5_ssum_nxt, s5_ssum_r;
  logic        s5_neg_r;
  logic [8:0]  s5_deg_r;
  logic [7:0]  s5_mins_r;

  always_comb begin
    mrem = s4_millis_r - 16'(s4_mq_r) * 16'(aps_pkg::THOUSAND);
    if (mrem >= 16'(aps_pkg::THOUSAND)) begin
      s5_milli_nxt = 10'(mrem - 16'(aps_pkg::THOUSAND));
      mcarry       = s4_mq_r + 7'd1;
    end else begin
      s5_milli_nxt = 10'(mrem);
      mcarry       = s4_mq_r;
    end
    s5_ssum_nxt = 9'(s4_secs_r) + 9'(mcarry);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_neg_r   <= s4_neg_r;
      s5_deg_r   <= s4_deg_r;
      s5_mins_r  <= s4_mins_r;
      s5_milli_r <= s5_milli_nxt;
      s5_ssum_r  <= s5_ssum_nxt;
    end
  end

  // stage 6: quotient estimate of seconds by 60
  logic [19:0] psec;
  logic [2:0]  s6_sq_nxt, s6_sq_r;
  logic        s6_neg_r;
  logic [8:0]  s6_deg_r, s6_ssum_r;
  logic [7:0]  s6_mins_r;
  logic [9:0]  s6_milli_r;

  always_comb begin
    psec      = 20'(s5_ssum_r) * 20'(aps_pkg::RECIP_60);
    s6_sq_nxt = 3'(psec >> aps_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_neg_r   <= s5_neg_r;
      s6_deg_r   <= s5_deg_r;
      s6_mins_r  <= s5_mins_r;
      s6_milli_r <= s5_milli_r;
      s6_ssum_r  <= s5_ssum_r;
      s6_sq_r    <= s6_sq_nxt;
    end
  end

  // stage 7: correct seconds, carry into minutes
  logic [8:0] srem;
  logic [2:0] scarry;
  logic [5:0] s7_sec_nxt, s7_sec_r;
  logic [8:0] s7_msum_nxt, s7_msum_r;
  logic       s7_neg_r;
  logic [8:0] s7_deg_r;
  logic [9:0] s7_milli_r;

  always_comb begin
    srem = s6_ssum_r - 9'(s6_sq_r) * 9'(aps_pkg::SIXTY);
    if (srem >= 9'(aps_pkg::SIXTY)) begin
      s7_sec_nxt = 6'(srem - 9'(aps_pkg::SIXTY));
      scarry     = s6_sq_r + 3'd1;
    end else begin
      s7_sec_nxt = 6'(srem);
      scarry     = s6_sq_r;
    end
    s7_msum_nxt = 9'(s6_mins_r) + 9'(scarry);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_neg_r   <= s6_neg_r;
      s7_deg_r   <= s6_deg_r;
      s7_milli_r <= s6_milli_r;
      s7_sec_r   <= s7_sec_nxt;
      s7_msum_r  <= s7_msum_nxt;
    end
  end

  // stage 8: quotient estimate of minutes by 60
  logic [19:0] pmin;
  logic [2:0]  s8_mq_nxt, s8_mq_r;
  logic        s8_neg_r;
  logic [8:0]  s8_deg_r, s8_msum_r;
  logic [9:0]  s8_milli_r;
  logic [5:0]  s8_sec_r;

  always_comb begin
    pmin      = 20'(s7_msum_r) * 20'(aps_pkg::RECIP_60);
    s8_mq_nxt = 3'(pmin >> aps_pkg::RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_neg_r   <= s7_neg_r;
      s8_deg_r   <= s7_deg_r;
      s8_milli_r <= s7_milli_r;
      s8_sec_r   <= s7_sec_r;
      s8_msum_r  <= s7_msum_r;
      s8_mq_r    <= s8_mq_nxt;
    end
  end

  // stage 9: correct minutes, carry into degrees, pack the word
  logic [8:0]        mnrem;
  logic [2:0]        dcarry;
  logic [5:0]        min_fin;
  logic [8:0]        dsum, deg_fin;
  aps_pkg::aps_out_t out_nxt, out_r;

  always_comb begin
    mnrem = s8_msum_r - 9'(s8_mq_r) * 9'(aps_pkg::SIXTY);
    if (mnrem >= 9'(aps_pkg::SIXTY)) begin
      min_fin = 6'(mnrem - 9'(aps_pkg::SIXTY));
      dcarry  = s8_mq_r + 3'd1;
    end else begin
      min_fin = 6'(mnrem);
      dcarry  = s8_mq_r;
    end
    dsum = s8_deg_r + 9'(dcarry);
    if (dsum >= 9'(aps_pkg::FULL_TURN)) begin
      deg_fin = dsum - 9'(aps_pkg::FULL_TURN);
    end else begin
      deg_fin = dsum;
    end
    out_nxt.packed_angle = {s8_neg_r, deg_fin, min_fin, s8_sec_r, s8_milli_r};
    out_nxt.negative     = s8_neg_r;
    out_nxt.degree_part  = deg_fin;
    out_nxt.minute_part  = min_fin;
    out_nxt.second_part  = s8_sec_r;
    out_nxt.milli_part   = s8_milli_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* design/angle_to_packed_sexagesimal.sv */
// ----------------------------------------------------------------------------
// Packed sexagesimal angle former
// Turns component angles or signed fixed-point angles into a packed word of
// sign, degrees modulo 360, minutes, seconds and thousandths of a second.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  aps_in_t  (mode and source fields)
//   out_     output     out_valid/out_stall aps_out_t (packed word and parts)
//
// One transaction per cycle sustained while out_stall stays low; a transaction passes
// the front end write, queue and nine datapath stages, the stages set by the three
// fraction multiplies and the carry chain from thousandths up to degrees.
// Reset clears queue pointers and stage valids; no reset sweep.
// A stalled result freezes the datapath; the 4-entry queue keeps in_stall low
// until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_to_packed_sexagesimal #(
  parameter int FRAC_BITS = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  aps_pkg::aps_in_t  in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output aps_pkg::aps_out_t       out_data
);

  aps_pkg::aps_qstat_t q_stat;
  aps_pkg::aps_entry_t q_entry;
  aps_pkg::aps_entry_t q_data;
  logic                q_push;
  logic                q_pop;

  aps_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  aps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .q_stat  (q_stat)
  );

  aps_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_angle_to_packed_sexagesimal.sv */
// ----------------------------------------------------------------------------
// Packed sexagesimal angle former testbench
// Drives component and fixed-point angles through the valid/stall input
// channel, predicts each packed word with an independent integer model and
// compares every result field in order, with random idling on both sides.
// ----------------------------------------------------------------------------

module tb_angle_to_packed_sexagesimal;

  localparam int FRAC_BITS = 32;
  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1730;

  class angle_scoreboard;
    aps_pkg::aps_out_t expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function aps_pkg::aps_out_t predict_sexagesimal(aps_pkg::aps_in_t item);
      logic              neg;
      logic [31:0]       whole_raw;
      logic [31:0]       whole_mag;
      logic [63:0]       angle_raw;
      logic [63:0]       angle_mag;
      logic [63:0]       deg_mag;
      logic [63:0]       mins;
      logic [63:0]       secs;
      logic [63:0]       millis;
      logic [63:0]       prod;
      logic [63:0]       turn_deg;
      aps_pkg::aps_out_t res;
      if (item.func == aps_pkg::FUNC_PACK) begin
        whole_raw = item.whole_degrees;
        neg = whole_raw[31];
        whole_mag = neg ? (32'd0 - whole_raw) : whole_raw;
        deg_mag = {32'd0, whole_mag};
        mins = {56'd0, item.arc_minutes};
        secs = {56'd0, item.arc_seconds};
        millis = {48'd0, item.thousandths};
      end else begin
        angle_raw = item.angle_fixed;
        neg = angle_raw[63];
        angle_mag = neg ? (64'd0 - angle_raw) : angle_raw;
        deg_mag = angle_mag >> FRAC_BITS;
        prod = (angle_mag & FRAC_MASK) * 64'd60;
        mins = prod >> FRAC_BITS;
        prod = (prod & FRAC_MASK) * 64'd60;
        secs = prod >> FRAC_BITS;
        prod = (prod & FRAC_MASK) * 64'd1000;
        millis = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
      secs = secs + millis / 64'd1000;
      millis = millis % 64'd1000;
      mins = mins + secs / 64'd60;
      secs = secs % 64'd60;
      turn_deg = (deg_mag % 64'd360 + mins / 64'd60) % 64'd360;
      mins = mins % 64'd60;
      res.packed_angle = {neg, turn_deg[8:0], mins[5:0], secs[5:0], millis[9:0]};
      res.negative = neg;
      res.degree_part = turn_deg[8:0];
      res.minute_part = mins[5:0];
      res.second_part = secs[5:0];
      res.milli_part = millis[9:0];
      return res;
    endfunction

    function void note_input(aps_pkg::aps_in_t item);
      expected_q.push_back(predict_sexagesimal(item));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      errors++;
    endtask

    task check_result(aps_pkg::aps_out_t got);
      aps_pkg::aps_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", got.packed_angle, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.packed_angle !== want.packed_angle)
          report("packed_angle", got.packed_angle, want.packed_angle);
        if (got.negative !== want.negative)
          report("negative", 32'(got.negative), 32'(want.negative));
        if (got.degree_part !== want.degree_part)
          report("degree_part", 32'(got.degree_part), 32'(want.degree_part));
        if (got.minute_part !== want.minute_part)
          report("minute_part", 32'(got.minute_part), 32'(want.minute_part));
        if (got.second_part !== want.second_part)
          report("second_part", 32'(got.second_part), 32'(want.second_part));
        if (got.milli_part !== want.milli_part)
          report("milli_part", 32'(got.milli_part), 32'(want.milli_part));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  aps_pkg::aps_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  aps_pkg::aps_out_t out_data;

  logic     steady = 1'b0;
  int       cycle_count = 0;
  angle_scoreboard sb;

  angle_to_packed_sexagesimal #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic aps_pkg::aps_in_t noise_item();
    aps_pkg::aps_in_t item;
    item.func = aps_pkg::FUNC_PACK;
    item.whole_degrees = $urandom;
    item.arc_minutes = 8'($urandom);
    item.arc_seconds = 8'($urandom);
    item.thousandths = 16'($urandom);
    item.angle_fixed = {$urandom, $urandom};
    return item;
  endfunction

  function automatic aps_pkg::aps_in_t component_angle(logic [31:0] whole, logic [7:0] m,
                                                       logic [7:0] s, logic [15:0] t);
    aps_pkg::aps_in_t item;
    item = noise_item();
    item.whole_degrees = whole;
    item.arc_minutes = m;
    item.arc_seconds = s;
    item.thousandths = t;
    return item;
  endfunction

  function automatic aps_pkg::aps_in_t fixed_angle(logic [63:0] angle);
    aps_pkg::aps_in_t item;
    item = noise_item();
    item.func = aps_pkg::FUNC_FIXED;
    item.angle_fixed = angle;
    return item;
  endfunction

  function automatic aps_pkg::aps_in_t random_angle();
    aps_pkg::aps_in_t item;
    logic [31:0]      whole;
    logic [31:0]      frac;
    int               pick;
    item = noise_item();
    pick = $urandom_range(9);
    if ($urandom_range(1) == 0) begin
      if (pick >= 4 && pick <= 7) begin
        item.whole_degrees = $urandom_range(1440) - 720;
        item.arc_minutes = 8'($urandom_range(59));
        item.arc_seconds = 8'($urandom_range(59));
        item.thousandths = 16'($urandom_range(999));
      end else if (pick >= 8) begin
        item.whole_degrees = $urandom_range(365) - 5;
        item.arc_minutes = 8'($urandom_range(70, 50));
        item.arc_seconds = 8'($urandom_range(70, 50));
        item.thousandths = 16'($urandom_range(1100, 900));
      end
    end else begin
      item.func = aps_pkg::FUNC_FIXED;
      whole = $urandom_range(2000) - 1000;
      frac = $urandom;
      if (pick >= 4 && pick <= 7) begin
        item.angle_fixed = {whole, frac};
      end else if (pick == 8) begin
        frac = ($urandom_range(1) == 0) ? (32'hFFFF_FFFF - $urandom_range(8191))
                                        : $urandom_range(8191);
        item.angle_fixed = {whole, frac};
      end else if (pick == 9) begin
        item.angle_fixed = 64'd0 - {32'd0, frac};
      end
    end
    return item;
  endfunction

  task automatic send_item(input aps_pkg::aps_in_t item);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_item(component_angle(32'd0, 8'd0, 8'd0, 16'd0));
    send_item(component_angle(32'h7FFF_FFFF, 8'd255, 8'd255, 16'd65535));
    send_item(component_angle(32'h8000_0000, 8'd0, 8'd0, 16'd0));
    send_item(component_angle(32'h8000_0001, 8'd59, 8'd59, 16'd999));
    send_item(component_angle(32'd359, 8'd59, 8'd59, 16'd999));
    send_item(component_angle(32'd359, 8'd59, 8'd59, 16'd1000));
    send_item(component_angle(32'hFFFF_FFFF, 8'd0, 8'd0, 16'd0));
    send_item(component_angle(32'd360, 8'd60, 8'd0, 16'd0));
    send_item(component_angle(32'd0, 8'd0, 8'd0, 16'd65535));
    send_item(component_angle(-32'sd720, 8'd255, 8'd255, 16'd0));
    send_item(component_angle(32'hFFFF_FFFF, 8'd255, 8'd255, 16'd65535));
    send_item(fixed_angle(64'd0));
    send_item(fixed_angle(64'h8000_0000_0000_0000));
    send_item(fixed_angle(64'h7FFF_FFFF_FFFF_FFFF));
    send_item(fixed_angle(64'hFFFF_FFFF_FFFF_FFFF));
    send_item(fixed_angle(64'd0 - 64'h0000_0000_8000_0000));
    send_item(fixed_angle({32'd360, 32'd0}));
    send_item(fixed_angle({32'd359, 32'hFFFF_FFFF}));
    send_item(fixed_angle({32'd1, 32'h0000_0001}));
    send_item(fixed_angle(64'd0 - {32'd12345, 32'h1234_5678}));
    send_item(fixed_angle(64'h8000_0000_0000_0001));
    send_item(fixed_angle({32'h7FFF_FFFF, 32'h8000_0000}));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 600 && n < 900);
      send_item(random_angle());
    end
    in_valid <= 1'b0;
    steady <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/aps_pkg.sv
design/aps_front.sv
design/aps_queue.sv
design/aps_back.sv
design/angle_to_packed_sexagesimal.sv
tb/sv/tb_angle_to_packed_sexagesimal.sv
